// File: rtl/sem_pkg.sv
// Shared types, constants and arithmetic helpers of the Sobel edge magnitude block.
package sem_pkg;

  localparam int MaxWidth   = 2048;
  localparam int MaxHeight  = 4096;
  localparam int ColW       = $clog2(MaxWidth);
  localparam int RowW       = $clog2(MaxHeight);
  localparam int CfgWidthW  = 12;
  localparam int CfgHeightW = 13;

  localparam logic [CfgWidthW-1:0]  WidthReset  = 12'd640;
  localparam logic [CfgHeightW-1:0] HeightReset = 13'd480;

  // register indexes, selected by paddr[2]
  localparam logic RegWidth  = 1'b0;
  localparam logic RegHeight = 1'b1;

  localparam int MidDepth       = 4;
  localparam int OutDepth       = 8;
  localparam int SqrtSteps      = 8;
  localparam int StepsPerStage  = 2;
  localparam int SqrtStages     = SqrtSteps / StepsPerStage;

  typedef logic [23:0] pix_t;

  typedef struct packed {
    logic [7:0] chan0;
    logic [7:0] chan1;
    logic [7:0] chan2;
  } in_word_t;

  typedef struct packed {
    logic [7:0]      edge0;
    logic [7:0]      edge1;
    logic [7:0]      edge2;
    logic [ColW-1:0] out_col;
    logic [RowW-1:0] out_row;
    logic            frame_last;
  } out_word_t;

  // one window column, top to bottom
  typedef struct packed {
    pix_t top;
    pix_t mid;
    pix_t bot;
  } col_t;

  typedef struct packed {
    logic            interior;
    logic [ColW-1:0] col;
    logic [RowW-1:0] row;
    logic            last;
  } meta_t;

  // front to back: full 3x3 neighborhood plus result tag
  typedef struct packed {
    col_t  l;
    col_t  m;
    col_t  r;
    meta_t meta;
  } win_t;

  typedef struct packed {
    logic signed [10:0] gx;
    logic signed [10:0] gy;
  } grad_t;

  typedef struct packed {
    logic [15:0] v;
    logic [15:0] r;
  } sq_t;

  // channel c of a pixel word; chan0 sits in the top byte
  function automatic logic signed [10:0] chan_px(input pix_t p, input int unsigned c);
    logic signed [10:0] x;
    x = $signed({3'b000, p[8*(2-c) +: 8]});
    return x;
  endfunction

  function automatic grad_t sobel_grad(input col_t l, input col_t m, input col_t r,
                                       input int unsigned c);
    logic signed [10:0] tl, ml, bl, tm, bm, tr, mr, br;
    grad_t g;
    tl = chan_px(l.top, c);
    ml = chan_px(l.mid, c);
    bl = chan_px(l.bot, c);
    tm = chan_px(m.top, c);
    bm = chan_px(m.bot, c);
    tr = chan_px(r.top, c);
    mr = chan_px(r.mid, c);
    br = chan_px(r.bot, c);
    g.gx = tl + (ml <<< 1) + bl - tr - (mr <<< 1) - br;
    g.gy = bl + (bm <<< 1) + br - tl - (tm <<< 1) - tr;
    return g;
  endfunction

  // one digit of the restoring square root; k counts down from SqrtSteps-1
  function automatic sq_t sqrt_step(input sq_t s, input logic [2:0] k);
    logic [15:0] b;
    logic [16:0] t;
    sq_t o;
    b = 16'd1 << {k, 1'b0};
    t = {1'b0, s.r} + {1'b0, b};
    o = s;
    if ({1'b0, s.v} >= t) begin
      o.v = s.v - t[15:0];
      o.r = (s.r >> 1) + b;
    end else begin
      o.r = s.r >> 1;
    end
    return o;
  endfunction

endpackage

// File: rtl/sem_fifo.sv
// Short queue of window words between the front and the back.
module sem_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr,
  input  sem_pkg::win_t wdata,
  output logic          full,
  input  logic          rd,
  output sem_pkg::win_t rdata,
  output logic          empty
);
  import sem_pkg::*;

  localparam int PtrW = $clog2(MidDepth);

  win_t            buf_q [MidDepth];
  logic [PtrW-1:0] wptr;
  logic [PtrW-1:0] rptr;
  logic [PtrW:0]   count;

  assign full  = (count == (PtrW+1)'(MidDepth));
  assign empty = (count == '0);
  assign rdata = buf_q[rptr];

  always_ff @(posedge clk) begin
    if (wr) begin
      buf_q[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (wr) begin
        wptr <= wptr + 1'b1;
      end
      if (rd) begin
        rptr <= rptr + 1'b1;
      end
      count <= count + (PtrW+1)'(wr) - (PtrW+1)'(rd);
    end
  end

endmodule

// File: rtl/sem_front.sv
// Front: pixel counters, line stores and column window; builds one window word per result.
module sem_front (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               restart,
  input  logic [sem_pkg::CfgWidthW-1:0]      w_eff,
  input  logic [sem_pkg::CfgHeightW-1:0]     h_eff,
  input  logic                               push,
  output logic                               full,
  input  sem_pkg::in_word_t                  pixel,
  input  logic                               q_full,
  output logic                               q_push,
  output sem_pkg::win_t                      q_data
);
  import sem_pkg::*;

  logic [ColW-1:0] col_count;
  logic [RowW-1:0] row_count;

  pix_t above_mem [MaxWidth];
  pix_t two_mem   [MaxWidth];
  pix_t rd_above;
  pix_t rd_two;

  logic            s1_valid;
  pix_t            s1_pix;
  logic [ColW-1:0] s1_idx;
  logic            s1_emit;
  meta_t           s1_meta;

  col_t win_l;
  col_t win_m;
  col_t cur;

  logic accept;
  logic s1_fire;
  logic col_end;
  logic row_end;

  assign col_end = ({1'b0, col_count} + CfgWidthW'(1)) >= w_eff;
  assign row_end = ({1'b0, row_count} + CfgHeightW'(1)) >= h_eff;

  assign full    = s1_valid && s1_emit && q_full;
  assign accept  = push && !full;
  assign s1_fire = s1_valid && !(s1_emit && q_full);
  assign q_push  = s1_valid && s1_emit && !q_full;

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      col_count <= '0;
      row_count <= '0;
    end else if (accept) begin
      if (col_end) begin
        col_count <= '0;
        row_count <= row_end ? '0 : row_count + 1'b1;
      end else begin
        col_count <= col_count + 1'b1;
      end
    end
  end

  // read at accept, write back when the item leaves stage 1; consecutive
  // hits on one entry only happen at width 1, where nothing is emitted
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_above <= above_mem[col_count];
      rd_two   <= two_mem[col_count];
    end
    if (s1_fire) begin
      above_mem[s1_idx] <= s1_pix;
      two_mem[s1_idx]   <= rd_above;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pix           <= pixel;
      s1_idx           <= col_count;
      s1_emit          <= (col_count != '0) && (row_count != '0);
      s1_meta.interior <= (col_count[ColW-1:1] != '0) && (row_count[RowW-1:1] != '0);
      s1_meta.col      <= col_count - 1'b1;
      s1_meta.row      <= row_count - 1'b1;
      s1_meta.last     <= col_end && row_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  assign cur = '{top: rd_two, mid: rd_above, bot: s1_pix};

  always_ff @(posedge clk) begin
    if (rst) begin
      win_l <= '0;
      win_m <= '0;
    end else if (s1_fire) begin
      win_l <= win_m;
      win_m <= cur;
    end
  end

  assign q_data = '{l: win_l, m: win_m, r: cur, meta: s1_meta};

endmodule

// File: rtl/sem_back.sv
// Back: Sobel gradients, squared magnitude, pipelined square root and result queue.
module sem_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_empty,
  input  sem_pkg::win_t      q_data,
  output logic               q_pop,
  output logic               empty,
  input  logic               pop,
  output sem_pkg::out_word_t result
);
  import sem_pkg::*;

  localparam int OPtrW = $clog2(OutDepth);

  // words taken from the queue and not yet popped at the output
  logic [OPtrW:0] reserved;

  logic  v1;
  grad_t g1 [3];
  meta_t m1;

  logic  [21:0] sqsum [3];
  logic         sv [SqrtStages+1];
  sq_t          ss [SqrtStages+1][3];
  meta_t        sm [SqrtStages+1];

  out_word_t      obuf [OutDepth];
  logic [OPtrW-1:0] wptr;
  logic [OPtrW-1:0] rptr;
  logic [OPtrW:0]   ocount;
  out_word_t      done;
  logic           out_pop;

  assign q_pop   = !q_empty && (reserved < (OPtrW+1)'(OutDepth));
  assign empty   = (ocount == '0);
  assign out_pop = pop && !empty;
  assign result  = obuf[rptr];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      sqsum[c] = 22'($signed(g1[c].gx) * $signed(g1[c].gx))
               + 22'($signed(g1[c].gy) * $signed(g1[c].gy));
    end
  end

  always_ff @(posedge clk) begin
    for (int c = 0; c < 3; c++) begin
      g1[c]      <= sobel_grad(q_data.l, q_data.m, q_data.r, c);
      ss[0][c].v <= sqsum[c][20:5];
      ss[0][c].r <= '0;
    end
    m1    <= q_data.meta;
    sm[0] <= m1;
    for (int k = 0; k < SqrtStages; k++) begin
      for (int c = 0; c < 3; c++) begin
        ss[k+1][c] <= sqrt_step(sqrt_step(ss[k][c], 3'(SqrtSteps - 1 - StepsPerStage*k)),
                                3'(SqrtSteps - 2 - StepsPerStage*k));
      end
      sm[k+1] <= sm[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      for (int k = 0; k <= SqrtStages; k++) begin
        sv[k] <= 1'b0;
      end
    end else begin
      v1    <= q_pop;
      sv[0] <= v1;
      for (int k = 0; k < SqrtStages; k++) begin
        sv[k+1] <= sv[k];
      end
    end
  end

  always_comb begin
    done.edge0      = sm[SqrtStages].interior ? ss[SqrtStages][0].r[7:0] : 8'd0;
    done.edge1      = sm[SqrtStages].interior ? ss[SqrtStages][1].r[7:0] : 8'd0;
    done.edge2      = sm[SqrtStages].interior ? ss[SqrtStages][2].r[7:0] : 8'd0;
    done.out_col    = sm[SqrtStages].col;
    done.out_row    = sm[SqrtStages].row;
    done.frame_last = sm[SqrtStages].last;
  end

  always_ff @(posedge clk) begin
    if (sv[SqrtStages]) begin
      obuf[wptr] <= done;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr     <= '0;
      rptr     <= '0;
      ocount   <= '0;
      reserved <= '0;
    end else begin
      if (sv[SqrtStages]) begin
        wptr <= wptr + 1'b1;
      end
      if (out_pop) begin
        rptr <= rptr + 1'b1;
      end
      ocount   <= ocount + (OPtrW+1)'(sv[SqrtStages]) - (OPtrW+1)'(out_pop);
      reserved <= reserved + (OPtrW+1)'(q_pop) - (OPtrW+1)'(out_pop);
    end
  end

endmodule

// File: rtl/sobel_edge_magnitude_top.sv
// Top level of the Sobel edge magnitude block: config registers, front, queue and back.
//
// Pixels enter in raster order through the push/full side, one word per clock
// for as long as results are popped; the block sustains one pixel per cycle.
// Each pixel outside row 0 and column 0 yields one result word for the pixel
// one up and one left; results in result row 0 or column 0 are zero, and the
// last row and column of the image are never produced. The front reads both line
// stores (2048 x 24 bits each) in the accept cycle and writes them back when the
// pixel leaves its stage-1 register, which feeds the queue and holds the pixel
// while its word is due and the queue is full. The back registers the gradients,
// then the squared sum, then runs the 8-digit square root two digits per pipeline
// stage and writes an 8-word result queue. It only draws from the middle queue
// while it has room reserved in its result queue, so full rises only once the middle
// queue has filled and all result queue room is reserved. Writing either size register
// restarts the frame at pixel (0,0); line store contents are kept and no clearing pass
// is needed. Sizes of 0 act as 1, and sizes beyond 2048 x 4096 are clamped.
module sobel_edge_magnitude_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               push,
  output logic               full,
  input  sem_pkg::in_word_t  pixel,
  output logic               empty,
  input  logic               pop,
  output sem_pkg::out_word_t result
);
  import sem_pkg::*;

  logic [CfgWidthW-1:0]  image_width;
  logic [CfgHeightW-1:0] image_height;
  logic [CfgWidthW-1:0]  w_eff;
  logic [CfgHeightW-1:0] h_eff;
  logic                  cfg_wr;

  logic  q_full;
  logic  q_empty;
  logic  q_push;
  logic  q_pop;
  win_t  q_wdata;
  win_t  q_rdata;

  // APB: no wait states; paddr[2] picks the register
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= WidthReset;
      image_height <= HeightReset;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        RegWidth:  image_width  <= pwdata[CfgWidthW-1:0];
        RegHeight: image_height <= pwdata[CfgHeightW-1:0];
        default:   image_width  <= image_width;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      RegWidth:  prdata = {{(32-CfgWidthW){1'b0}}, image_width};
      RegHeight: prdata = {{(32-CfgHeightW){1'b0}}, image_height};
      default:   prdata = '0;
    endcase
  end

  // effective sizes: zero acts as one, oversize is clamped
  always_comb begin
    if (image_width == '0) begin
      w_eff = CfgWidthW'(1);
    end else if (image_width > CfgWidthW'(MaxWidth)) begin
      w_eff = CfgWidthW'(MaxWidth);
    end else begin
      w_eff = image_width;
    end
    if (image_height == '0) begin
      h_eff = CfgHeightW'(1);
    end else if (image_height > CfgHeightW'(MaxHeight)) begin
      h_eff = CfgHeightW'(MaxHeight);
    end else begin
      h_eff = image_height;
    end
  end

  sem_front u_front (
    .clk     (clk),
    .rst     (rst),
    .restart (cfg_wr),
    .w_eff   (w_eff),
    .h_eff   (h_eff),
    .push    (push),
    .full    (full),
    .pixel   (pixel),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_data  (q_wdata)
  );

  sem_fifo u_queue (
    .clk   (clk),
    .rst   (rst),
    .wr    (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .rd    (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  sem_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_data  (q_rdata),
    .q_pop   (q_pop),
    .empty   (empty),
    .pop     (pop),
    .result  (result)
  );

  // result queue comes out of reset empty
  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result queue not empty after reset");

  // the input side only stalls on a full middle queue
  a_full_cause: assert property (@(posedge clk) disable iff (rst) full |-> q_full)
    else $error("full raised while middle queue has room");

  // border results carry zero magnitude
  a_border_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && (result.out_row == '0 || result.out_col == '0)) |->
    (result.edge0 == 8'd0 && result.edge1 == 8'd0 && result.edge2 == 8'd0))
    else $error("nonzero edge on border result");

endmodule

// File: bench/tb_sobel_edge_magnitude_top.sv
// Self-checking testbench for the Sobel edge magnitude block: raster pixels in, edge words out.
module tb_sobel_edge_magnitude_top;
  timeunit 1ns;
  timeprecision 1ps;

  import sem_pkg::*;

  // drain time after the last expected word: pipe depth plus queue slack
  localparam int DrainCycles   = 32;
  // cycles with no handshake on either side before the run is declared hung
  localparam int WatchdogLimit = 5000;
  // random pixels to push after the directed part
  localparam int RandomTarget  = 1200;

  typedef enum int {
    PatNoise,      // uniform random bytes
    PatExtreme,    // bytes drawn mostly from 0 and 255
    PatColStripe,  // vertical bars, one bit of the column per channel
    PatRowStripe,  // horizontal bars from row bits 0 and 1, checkerboard in the third channel
    PatCorner,     // left column / bottom row lit: large Gx, Gy, both
    PatFlat        // all 255: zero gradient everywhere
  } pattern_e;

  logic        clk;
  logic        rst     = 1'b1;
  logic        psel    = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite  = 1'b0;
  logic [2:0]  paddr   = '0;
  logic [31:0] pwdata  = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        push    = 1'b0;
  logic        full;
  in_word_t    pixel   = '0;
  logic        empty;
  logic        pop     = 1'b0;
  out_word_t   result;

  sobel_edge_magnitude_top dut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .push    (push),
    .full    (full),
    .pixel   (pixel),
    .empty   (empty),
    .pop     (pop),
    .result  (result)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // ---------------------------------------------------------------------------
  // Shadow copy of the block: line stores, 2-column window, raster position and
  // the two size registers. Updated on every accepted pixel and register write.
  // ---------------------------------------------------------------------------
  in_word_t    row_above     [MaxWidth];
  in_word_t    row_two_above [MaxWidth];
  in_word_t    win_cols      [6];   // [0..2] column x-2 top..bot, [3..5] column x-1
  int unsigned pos_col;
  int unsigned pos_row;
  logic [11:0] width_reg;
  logic [12:0] height_reg;

  in_word_t  pending_pixels [$];  // words waiting for the driver
  out_word_t due_edges      [$];  // predicted words, oldest first

  int errors         = 0;
  int pixels_in      = 0;
  int edges_out      = 0;
  int frame_ends     = 0;
  int setups         = 0;
  int idle_cycles    = 0;
  int send_idle_pct  = 0;
  int stall_pct      = 0;

  // 0 acts as 1, anything past cap (line store depth or max height) is clamped
  function automatic int unsigned eff_span(input logic [12:0] v, input int unsigned cap);
    if (v == 0) return 1;
    if (v > cap) return cap;
    return v;
  endfunction

  function automatic int lane(input in_word_t p, input int c);
    case (c)
      0:       return p.chan0;
      1:       return p.chan1;
      default: return p.chan2;
    endcase
  endfunction

  // floor square root by bisection on the 8 result bits
  function automatic int unsigned root_floor(input int unsigned v);
    int unsigned r;
    r = 0;
    for (int b = 128; b > 0; b >>= 1)
      if ((r + b) * (r + b) <= v) r += b;
    return r;
  endfunction

  function automatic logic [7:0] edge_of(input in_word_t tl, ml, bl, tm, bm, tr, mr, br,
                                         input int c);
    int          gx;
    int          gy;
    int unsigned q;
    gx = lane(tl, c) + 2 * lane(ml, c) + lane(bl, c)
       - lane(tr, c) - 2 * lane(mr, c) - lane(br, c);
    gy = lane(bl, c) + 2 * lane(bm, c) + lane(br, c)
       - lane(tl, c) - 2 * lane(tm, c) - lane(tr, c);
    q = root_floor(int'(gx * gx + gy * gy) >> 5);
    return (q > 255) ? 8'd255 : q[7:0];
  endfunction

  // Advance the shadow copy by one pixel; queue the edge word it produces, if any.
  task automatic sobel_predict(input in_word_t px);
    int unsigned w;
    int unsigned h;
    int unsigned col;
    int unsigned row;
    in_word_t    top;
    in_word_t    mid;
    logic [7:0]  mag [3];
    out_word_t   o;
    w   = eff_span({1'b0, width_reg}, MaxWidth);
    h   = eff_span(height_reg, MaxHeight);
    col = pos_col;
    row = pos_row;
    top = row_two_above[col];
    mid = row_above[col];
    // row 0 and column 0 only prime the window
    if (col >= 1 && row >= 1) begin
      for (int c = 0; c < 3; c++)
        mag[c] = (col >= 2 && row >= 2) ?
                 edge_of(win_cols[0], win_cols[1], win_cols[2], win_cols[3], win_cols[5],
                         top, mid, px, c) : 8'd0;
      o.edge0      = mag[0];
      o.edge1      = mag[1];
      o.edge2      = mag[2];
      o.out_col    = ColW'(col - 1);
      o.out_row    = RowW'(row - 1);
      o.frame_last = (col + 1 >= w) && (row + 1 >= h);
      due_edges.push_back(o);
    end
    row_two_above[col] = mid;
    row_above[col]     = px;
    win_cols[0] = win_cols[3];
    win_cols[1] = win_cols[4];
    win_cols[2] = win_cols[5];
    win_cols[3] = top;
    win_cols[4] = mid;
    win_cols[5] = px;
    if (col + 1 >= w) begin
      pos_col = 0;
      pos_row = (row + 1 >= h) ? 0 : row + 1;
    end else begin
      pos_col = col + 1;
    end
  endtask

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  task automatic check_edge(input out_word_t got);
    out_word_t want;
    if (due_edges.size() == 0) begin
      $error("edge word with nothing expected: col %0d row %0d", got.out_col, got.out_row);
      errors++;
    end else begin
      want = due_edges.pop_front();
      compare_field("edge0",      32'(want.edge0),      32'(got.edge0));
      compare_field("edge1",      32'(want.edge1),      32'(got.edge1));
      compare_field("edge2",      32'(want.edge2),      32'(got.edge2));
      compare_field("out_col",    32'(want.out_col),    32'(got.out_col));
      compare_field("out_row",    32'(want.out_row),    32'(got.out_row));
      compare_field("frame_last", 32'(want.frame_last), 32'(got.frame_last));
      if (want.frame_last) frame_ends++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Driver: new push/pixel and pop at the falling edge, one assignment each.
  // The head word leaves the pending queue only once it is taken.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      push <= 1'b0;
      pop  <= 1'b0;
    end else begin
      if (pending_pixels.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        push  <= 1'b1;
        pixel <= pending_pixels[0];
      end else begin
        push <= 1'b0;
      end
      pop <= ($urandom_range(99) >= stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: both handshakes sampled at the rising edge; watchdog on no progress.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    logic moved;
    if (!rst) begin
      moved = 1'b0;
      if (push && !full) begin
        sobel_predict(pixel);
        pending_pixels.delete(0);
        pixels_in++;
        moved = 1'b1;
      end
      if (pop && !empty) begin
        check_edge(result);
        edges_out++;
        moved = 1'b1;
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
        $display("watchdog: no word moved in %0d cycles, %0d still expected",
                 WatchdogLimit, due_edges.size());
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  // Two-phase register write; lands at the edge with psel/penable/pwrite up.
  task automatic reg_write(input logic idx, input logic [31:0] value);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = value;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    if (idx == RegWidth) width_reg = value[11:0];
    else                 height_reg = value[12:0];
    // any write restarts the frame; stores and window are kept
    pos_col = 0;
    pos_row = 0;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // Wait for every pushed pixel and every expected word, then let the pipe drain
  // so a pixel that yields no word is surely done before the next write.
  task automatic settle();
    while (pending_pixels.size() != 0 || due_edges.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic set_idling(input int mode);
    case (mode % 4)
      0:       begin send_idle_pct = 0;  stall_pct = 0;  end
      1:       begin send_idle_pct = 60; stall_pct = 0;  end
      2:       begin send_idle_pct = 0;  stall_pct = 60; end
      default: begin send_idle_pct = 19; stall_pct = 19; end
    endcase
  endtask

  function automatic logic [7:0] bar(input bit lit);
    return lit ? 8'hFF : 8'h00;
  endfunction

  function automatic logic [7:0] extreme_byte();
    case ($urandom_range(2))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic in_word_t make_pixel(input pattern_e pat, input int k, input int w);
    int       col;
    int       row;
    in_word_t p;
    col = k % w;
    row = k / w;
    case (pat)
      PatExtreme: begin
        p.chan0 = extreme_byte();
        p.chan1 = extreme_byte();
        p.chan2 = extreme_byte();
      end
      PatColStripe: begin
        p.chan0 = bar(col[0]);
        p.chan1 = bar(col[1]);
        p.chan2 = bar(col[2]);
      end
      PatRowStripe: begin
        p.chan0 = bar(row[0]);
        p.chan1 = bar(row[1]);
        p.chan2 = bar(row[0] ^ col[0]);
      end
      PatCorner: begin
        p.chan0 = bar(col == 0);
        p.chan1 = bar(row == 2);
        p.chan2 = bar(col == 0 || row == 2);
      end
      PatFlat:  p = '1;
      default:  p = 24'($urandom);
    endcase
    return p;
  endfunction

  // Write both size registers, queue n pixels of one pattern, wait until done.
  task automatic run_frames(input logic [31:0] wv, input logic [31:0] hv, input int n,
                            input pattern_e pat);
    int w;
    w = eff_span({1'b0, wv[11:0]}, MaxWidth);
    reg_write(RegWidth, wv);
    reg_write(RegHeight, hv);
    setups++;
    for (int k = 0; k < n; k++) pending_pixels.push_back(make_pixel(pat, k, w));
    settle();
  endtask

  initial begin : stimulus
    int       phase;
    int       random_pixels;
    int       pick;
    int       w;
    int       h;
    int       n;
    pattern_e pat;
    // shadow copy starts as the block does after reset; its uncleared line stores start at zero here
    for (int i = 0; i < MaxWidth; i++) begin
      row_above[i]     = '0;
      row_two_above[i] = '0;
    end
    foreach (win_cols[i]) win_cols[i] = '0;
    pos_col    = 0;
    pos_row    = 0;
    width_reg  = WidthReset;
    height_reg = HeightReset;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: 3x3 frame with a strong Gx, Gy and both, then a flat frame
    // (zero gradient, all-ones input), then the thin and zero-size cases.
    set_idling(0);
    run_frames(3, 3, 9, PatCorner);
    run_frames(3, 3, 9, PatFlat);
    run_frames(0, 5, 3, PatNoise);   // width 0 acts as 1: never a word
    run_frames(4, 1, 5, PatNoise);   // height 1: never a word, wraps mid-stream
    run_frames(1, 3, 2, PatExtreme);

    // Size extremes: both registers at all ones (clamped to 2048 x 4096) over
    // the start of the first row; then exact max height on a narrow image.
    set_idling(3);
    run_frames(32'hFFF, 32'h1FFF, 600, PatNoise);
    set_idling(1);
    run_frames(3, MaxHeight, 40, PatExtreme);

    // Random: mostly whole small frames, sometimes cut short so the next write
    // restarts mid-frame; a few medium widths and thin shapes. Idling rotates
    // through the four modes per setup.
    phase         = 0;
    random_pixels = 0;
    while (random_pixels < RandomTarget) begin
      set_idling(phase);
      phase++;
      pick = $urandom_range(99);
      if (pick < 5) begin
        w = $urandom_range(1);
        h = $urandom_range(6, 2);
      end else if (pick < 10) begin
        w = $urandom_range(9, 2);
        h = $urandom_range(1);
      end else if (pick < 85) begin
        w = $urandom_range(9, 2);
        h = $urandom_range(7, 2);
      end else begin
        w = $urandom_range(48, 10);
        h = $urandom_range(5, 2);
      end
      n = eff_span(13'(w), MaxWidth) * eff_span(13'(h), MaxHeight);
      n = n * $urandom_range(3, 1) + (($urandom_range(2) == 0) ? $urandom_range(n - 1) : 0);
      if (n > 400) n = 400;
      pat = pattern_e'($urandom_range(PatRowStripe));
      run_frames(w, h, n, pat);
      random_pixels += n;
    end

    $display("covered %0d pixels over %0d size setups (thin, zero, clamped, max, random)",
             pixels_in, setups);
    $display("checked %0d edge words, %0d of them frame ends", edges_out, frame_ends);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
